// ===== rtl/core/tfd_pkg.sv =====
// Shared types, widths and constant tables of the tilt face detector.
package tfd_pkg;

  // Field and register widths
  localparam int AXW   = 16;   // raw axis word
  localparam int TSW   = 32;   // timestamp
  localparam int SIDEW = 7;    // side code
  localparam int HOLDW = 16;   // hold time
  localparam int AW    = 4;    // APB byte address
  localparam int DW    = 32;   // APB data

  // Axis mapping: (v - lo) * 180 / (hi - lo) - 90
  localparam int DIFW  = AXW + 1;        // v - lo and hi - lo
  localparam int PRODW = DIFW + 8;       // times 180
  localparam int NUMW  = PRODW - 1;      // dividend magnitude
  localparam int DENW  = DIFW;           // divisor magnitude
  localparam int MW    = NUMW + 2;       // mapped value, signed
  localparam int DCW   = $clog2(NUMW + 1);

  // Angle unit
  localparam int ANGLE_ITERATIONS = 16;
  localparam int TABLE_LEN = 24;
  localparam int FRAC  = 16;
  localparam int CW    = MW + FRAC + 4;  // rotation vector, signed
  localparam int ZW    = 32;             // angle accumulator, signed
  localparam int IW    = $clog2(TABLE_LEN + 1);
  localparam int ANGW  = 17;             // degrees * 256

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW:0]   DEG360 = (ZW + 1)'(360 * 65536);

  localparam logic signed [ZW-1:0] ATAN_DEG16 [TABLE_LEN] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
    32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
    32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  // Face windows on the first angle, degrees * 256, exclusive bounds
  localparam logic [ANGW-1:0] WIN1_LO = ANGW'(70 * 256);
  localparam logic [ANGW-1:0] WIN1_HI = ANGW'(100 * 256);
  localparam logic [ANGW-1:0] WIN2_LO = ANGW'(230 * 256);
  localparam logic [ANGW-1:0] WIN2_HI = ANGW'(290 * 256);
  localparam logic [8:0]      DEG_LAST = 9'd355;

  // Divide by 360 as a reciprocal multiply, exact for products below 2^16
  localparam int PW = 16;
  localparam int RSHIFT = 24;
  localparam logic [PW-1:0] RECIP360 = PW'(((1 << RSHIFT) + 359) / 360);

  // Register indexes
  localparam logic [1:0] REG_NSIDES = 2'd0;
  localparam logic [1:0] REG_MINRAW = 2'd1;
  localparam logic [1:0] REG_MAXRAW = 2'd2;
  localparam logic [1:0] REG_HOLD   = 2'd3;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic ang_start;
    logic classify;
    logic pick_side;
    logic commit;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic div_busy;
    logic ang_busy;
  } stat_t;

endpackage

// ===== rtl/core/tilt_face_detect_debounce.sv =====
// Top level of the tilt face detector: register file, sequencer and datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one accelerometer word: three
// raw signed axes and a millisecond timestamp. Output channel
// (out_valid_o/out_ready_i) returns exactly one result word per input word:
// the side classified from that sample, and a report flag with the side when
// a new side has held longer than hold_ms.
// Registers are written over the APB port; write them only while idle.
// Each word passes in order through capture, launch, the three axis dividers
// running side by side (one quotient bit per cycle), the two angle units
// running side by side (one rotation per cycle), classification and the
// write of the result register. One word is worked on at a time; the next
// word is taken as soon as the previous result sits in the output register,
// even if the receiver has not yet taken it.
// When the receiver stalls, the result holds and the following word waits in
// its final step. Reset clears the sequencer, the output valid and the
// debounce state, and loads the register defaults (6 sides, bounds 265 and
// 402, hold 5000 ms).
module tilt_face_detect_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tfd_pkg::AW-1:0]         paddr,
  input  logic [tfd_pkg::DW-1:0]         pwdata,
  output logic [tfd_pkg::DW-1:0]         prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [tfd_pkg::AXW-1:0] accel_x_i,
  input  logic signed [tfd_pkg::AXW-1:0] accel_y_i,
  input  logic signed [tfd_pkg::AXW-1:0] accel_z_i,
  input  logic [tfd_pkg::TSW-1:0]        now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           report_valid_o,
  output logic [tfd_pkg::SIDEW-1:0]      stable_side_o,
  output logic [tfd_pkg::SIDEW-1:0]      current_side_o
);
  import tfd_pkg::*;

  logic [SIDEW-1:0] nsides_q;
  logic [AXW-1:0]   min_raw_q, max_raw_q;
  logic [HOLDW-1:0] hold_q;
  logic             wr;
  logic [1:0]       idx;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsides_q  <= SIDEW'(6);
      min_raw_q <= AXW'(265);
      max_raw_q <= AXW'(402);
      hold_q    <= HOLDW'(5000);
    end else if (wr) begin
      unique case (idx)
        REG_NSIDES: nsides_q  <= pwdata[SIDEW-1:0];
        REG_MINRAW: min_raw_q <= pwdata[AXW-1:0];
        REG_MAXRAW: max_raw_q <= pwdata[AXW-1:0];
        REG_HOLD:   hold_q    <= pwdata[HOLDW-1:0];
        default:    hold_q    <= hold_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_NSIDES: prdata = DW'(nsides_q);
      REG_MINRAW: prdata = DW'(min_raw_q);
      REG_MAXRAW: prdata = DW'(max_raw_q);
      REG_HOLD:   prdata = DW'(hold_q);
      default:    prdata = '0;
    endcase
  end

  tfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tfd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .nsides_i       (nsides_q),
    .min_raw_i      (min_raw_q),
    .max_raw_i      (max_raw_q),
    .hold_i         (hold_q),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .now_ms_i       (now_ms_i),
    .report_valid_o (report_valid_o),
    .stable_side_o  (stable_side_o),
    .current_side_o (current_side_o)
  );

endmodule

// ===== rtl/core/tfd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tfd_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [tfd_pkg::NUMW-1:0] num_i,
  input  logic [tfd_pkg::DENW-1:0] den_i,
  output logic                    busy_o,
  output logic [tfd_pkg::NUMW-1:0] quo_o
);
  import tfd_pkg::*;

  logic              busy_q, busy_d;
  logic [DCW-1:0]    cnt_q, cnt_d;
  logic [NUMW-1:0]   quo_q, quo_d;
  logic [DENW-1:0]   rem_q, rem_d;
  logic [DENW:0]     trial;
  logic [DENW:0]     diff;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    trial  = {rem_q, quo_q[NUMW-1]};
    diff   = trial - {1'b0, den_i};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCW'(NUMW);
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = diff[DENW-1:0];
        quo_d = {quo_q[NUMW-2:0], 1'b1};
      end else begin
        rem_d = trial[DENW-1:0];
        quo_d = {quo_q[NUMW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/tfd_cordic.sv =====
// Vectoring CORDIC that returns atan2(a, b) + 180 degrees, 8 fraction bits.
module tfd_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [tfd_pkg::MW-1:0] a_i,
  input  logic signed [tfd_pkg::MW-1:0] b_i,
  output logic                          busy_o,
  output logic [tfd_pkg::ANGW-1:0]      angle_o
);
  import tfd_pkg::*;

  logic                 busy_q;
  logic [IW-1:0]        cnt_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [ANGW-1:0]      angle_q;

  logic signed [CW-1:0] a_ext, b_ext, xs, ys;
  logic signed [ZW:0]   tot, clamped, rnd;

  assign a_ext = {{(CW - MW - FRAC){a_i[MW-1]}}, a_i, {FRAC{1'b0}}};
  assign b_ext = {{(CW - MW - FRAC){b_i[MW-1]}}, b_i, {FRAC{1'b0}}};
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;

  // Offset by half a turn, clamp to a full turn, round to 8 fraction bits
  always_comb begin
    tot = {z_q[ZW-1], z_q} + {DEG180[ZW-1], DEG180};
    if (tot < 0) begin
      clamped = '0;
    end else if (tot > DEG360) begin
      clamped = DEG360;
    end else begin
      clamped = tot;
    end
    rnd = clamped + (ZW + 1)'(128);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= (a_i == '0 || b_i == '0) ? IW'(ANGLE_ITERATIONS) : '0;
    end else if (busy_q) begin
      if (cnt_q == IW'(ANGLE_ITERATIONS)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Load the vector, rotate toward the positive x axis, finish
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (a_i == '0) begin
        x_q <= b_ext;
        y_q <= a_ext;
        z_q <= (b_i >= 0) ? '0 : DEG180;
      end else if (b_i == '0) begin
        x_q <= b_ext;
        y_q <= a_ext;
        z_q <= (a_i > 0) ? DEG90 : -DEG90;
      end else if (b_i < 0) begin
        x_q <= -b_ext;
        y_q <= -a_ext;
        z_q <= (a_i > 0) ? DEG180 : -DEG180;
      end else begin
        x_q <= b_ext;
        y_q <= a_ext;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (cnt_q == IW'(ANGLE_ITERATIONS)) begin
        angle_q <= rnd[ANGW+7:8];
      end else if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ATAN_DEG16[cnt_q];
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ATAN_DEG16[cnt_q];
      end
    end
  end

  assign busy_o  = busy_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/core/tfd_datapath.sv =====
// Datapath: axis mapping, two angle units, side classification, debounce state.
module tfd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tfd_pkg::cmd_t                 cmd_i,
  output tfd_pkg::stat_t                stat_o,
  input  logic [tfd_pkg::SIDEW-1:0]     nsides_i,
  input  logic [tfd_pkg::AXW-1:0]       min_raw_i,
  input  logic [tfd_pkg::AXW-1:0]       max_raw_i,
  input  logic [tfd_pkg::HOLDW-1:0]     hold_i,
  input  logic signed [tfd_pkg::AXW-1:0] accel_x_i,
  input  logic signed [tfd_pkg::AXW-1:0] accel_y_i,
  input  logic signed [tfd_pkg::AXW-1:0] accel_z_i,
  input  logic [tfd_pkg::TSW-1:0]       now_ms_i,
  output logic                          report_valid_o,
  output logic [tfd_pkg::SIDEW-1:0]     stable_side_o,
  output logic [tfd_pkg::SIDEW-1:0]     current_side_o
);
  import tfd_pkg::*;

  // Captured word
  logic signed [AXW-1:0] ax_q [3];
  logic [TSW-1:0]        now_q;

  // Mapping
  logic signed [DIFW-1:0]  den;
  logic [DENW-1:0]         den_mag;
  logic signed [DIFW-1:0]  dif  [3];
  logic signed [PRODW-1:0] prod [3];
  logic [NUMW-1:0]         num  [3];
  logic [NUMW-1:0]         quo  [3];
  logic                    neg_q [3];
  logic                    dz_q;
  logic signed [MW-1:0]    qs   [3];
  logic signed [MW-1:0]    m    [3];
  logic [2:0]              dbusy;

  // Angles and classification
  logic [ANGW-1:0]         a1, a2;
  logic [1:0]              abusy;
  logic [8:0]              deg;
  logic [PW-1:0]           p_q;
  logic                    face_q, big_q;
  logic [2*PW-1:0]         scaled;
  logic [SIDEW-1:0]        side_q;

  // Debounce state and result word
  logic [SIDEW-1:0]        last_q;
  logic [TSW-1:0]          ct_q;
  logic                    rep_q;
  logic [TSW-1:0]          age;
  logic                    fire;
  logic                    rv_q;
  logic [SIDEW-1:0]        ss_q, cs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q[0] <= accel_x_i;
      ax_q[1] <= accel_y_i;
      ax_q[2] <= accel_z_i;
      now_q   <= now_ms_i;
    end
  end

  // Form numerator and divisor magnitudes and the quotient sign
  assign den     = DIFW'($signed(max_raw_i)) - DIFW'($signed(min_raw_i));
  assign den_mag = den[DIFW-1] ? DENW'(-den) : DENW'(den);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign dif[k]  = DIFW'(ax_q[k]) - DIFW'($signed(min_raw_i));
    assign prod[k] = PRODW'(dif[k]) * PRODW'(180);
    assign num[k]  = prod[k][PRODW-1] ? NUMW'(-prod[k]) : NUMW'(prod[k]);
    assign qs[k]   = neg_q[k] ? -MW'(quo[k]) : MW'(quo[k]);
    assign m[k]    = dz_q ? -MW'(90) : qs[k] - MW'(90);

    tfd_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.div_start),
      .num_i   (num[k]),
      .den_i   (den_mag),
      .busy_o  (dbusy[k]),
      .quo_o   (quo[k])
    );

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_start) begin
        neg_q[k] <= prod[k][PRODW-1] ^ den[DIFW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dz_q <= (den == '0);
    end
  end

  // First angle from y and z, second from x and z
  tfd_cordic u_ang1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ang_start),
    .a_i     (-m[1]),
    .b_i     (-m[2]),
    .busy_o  (abusy[0]),
    .angle_o (a1)
  );

  tfd_cordic u_ang2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ang_start),
    .a_i     (-m[0]),
    .b_i     (-m[2]),
    .busy_o  (abusy[1]),
    .angle_o (a2)
  );

  assign stat_o.div_busy = |dbusy;
  assign stat_o.ang_busy = |abusy;

  // Classify: face window test and bucket product
  assign deg = a2[ANGW-1:8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      face_q <= (a1 > WIN1_LO && a1 < WIN1_HI) || (a1 > WIN2_LO && a1 < WIN2_HI);
      big_q  <= deg > DEG_LAST;
      p_q    <= PW'(deg) * PW'(nsides_i);
    end
  end

  // Divide the bucket product by 360
  assign scaled = p_q * RECIP360;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_side) begin
      if (face_q) begin
        side_q <= nsides_i;
      end else if (big_q) begin
        side_q <= '0;
      end else begin
        side_q <= scaled[RSHIFT+SIDEW-1:RSHIFT];
      end
    end
  end

  // Debounce: restart on change, report once after the hold time
  assign age  = now_q - ct_q;
  assign fire = (side_q == last_q) && (age > TSW'(hold_i)) && !rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      ct_q   <= '0;
      rep_q  <= 1'b0;
    end else if (cmd_i.commit) begin
      if (side_q != last_q) begin
        last_q <= side_q;
        ct_q   <= now_q;
        rep_q  <= 1'b0;
      end else if (fire) begin
        rep_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rv_q <= fire;
      ss_q <= fire ? side_q : '0;
      cs_q <= side_q;
    end
  end

  assign report_valid_o = rv_q;
  assign stable_side_o  = ss_q;
  assign current_side_o = cs_q;

endmodule

// ===== rtl/core/tfd_ctrl.sv =====
// Sequencer that steps one sample through mapping, angles, classification, debounce.
module tfd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tfd_pkg::cmd_t  cmd_o,
  input  tfd_pkg::stat_t stat_i
);
  import tfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVGO,
    S_DIVW,
    S_ANGW,
    S_CLS,
    S_SIDE,
    S_PUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   put;

  assign in_ready_o = (state_q == S_IDLE);
  assign put        = (state_q == S_PUT) && (!out_valid_q || out_ready_i);

  // Decode commands from the state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_DIVGO);
    cmd_o.ang_start = (state_q == S_DIVW) && !stat_i.div_busy;
    cmd_o.classify  = (state_q == S_ANGW) && !stat_i.ang_busy;
    cmd_o.pick_side = (state_q == S_CLS);
    cmd_o.commit    = put;
  end

  // Advance the sequence and hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (put) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_valid_i) begin
          state_q <= S_DIVGO;
        end
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW:  if (!stat_i.div_busy) begin
          state_q <= S_ANGW;
        end
        S_ANGW:  if (!stat_i.ang_busy) begin
          state_q <= S_CLS;
        end
        S_CLS:   state_q <= S_SIDE;
        S_SIDE:  state_q <= S_PUT;
        S_PUT:   if (put) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/tfd_checker.sv =====
// Port-level checks for the tilt face detector, bound to the top level.
module tfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           pready,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           report_valid_o,
  input logic [tfd_pkg::SIDEW-1:0]      stable_side_o,
  input logic [tfd_pkg::SIDEW-1:0]      current_side_o
);

  // Busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // Silent report carries a zero side
  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> stable_side_o == '0)
    else $error("stable side set without report");

  // Reported side is the current side
  a_report_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o |-> stable_side_o == current_side_o)
    else $error("reported side differs from current side");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_side_o)
      && $stable(report_valid_o))
    else $error("result changed while stalled");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tilt_face_detect_debounce tfd_checker u_tfd_checker (.*);

// ===== tb/tb_tilt_face_detect_debounce.sv =====
// Testbench for the tilt face detector: APB setup, directed and random words, scoreboard check.
module tb_tilt_face_detect_debounce;
  import tfd_pkg::*;

  localparam int LIMIT_CYCLES = 900000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic             report;
    logic [SIDEW-1:0] stable;
    logic [SIDEW-1:0] side;
  } face_result_t;

  // Predict the face result of each word and compare against the block
  class face_scoreboard;
    logic [SIDEW-1:0] n_sides;
    logic [AXW-1:0]   lo_raw;
    logic [AXW-1:0]   hi_raw;
    logic [HOLDW-1:0] hold;
    logic [SIDEW-1:0] prev_side;
    logic [TSW-1:0]   changed_at;
    logic             reported;
    face_result_t     pending[$];
    int               errors;

    function new();
      n_sides = 6; lo_raw = 265; hi_raw = 402; hold = 5000;
      prev_side = '0; changed_at = '0; reported = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DW-1:0] val);
      case (idx)
        REG_NSIDES: n_sides = val[SIDEW-1:0];
        REG_MINRAW: lo_raw = val[AXW-1:0];
        REG_MAXRAW: hi_raw = val[AXW-1:0];
        REG_HOLD:   hold = val[HOLDW-1:0];
        default: ;
      endcase
    endfunction

    function longint scale_axis(logic signed [AXW-1:0] v);
      longint lo, span;
      lo = longint'($signed(lo_raw));
      span = longint'($signed(hi_raw)) - lo;
      if (span == 0) return -90;
      return ((longint'(v) - lo) * 180) / span - 90;
    endfunction

    // atan2(a, b) + 180 in degrees with 8 fraction bits
    function int unsigned tilt_angle(longint a, longint b);
      longint total, x, y, z, base, xs, ys;
      z = 0; base = 0;
      if (a == 0) total = (b >= 0) ? 0 : longint'(DEG180);
      else if (b == 0) total = (a > 0) ? longint'(DEG90) : -longint'(DEG90);
      else begin
        x = b * 65536;
        y = a * 65536;
        if (x < 0) begin
          base = (y > 0) ? longint'(DEG180) : -longint'(DEG180);
          x = -x;
          y = -y;
        end
        for (int i = 0; i < ANGLE_ITERATIONS && i < TABLE_LEN; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y > 0) begin
            x += ys; y -= xs; z += longint'(ATAN_DEG16[i]);
          end else begin
            x -= ys; y += xs; z -= longint'(ATAN_DEG16[i]);
          end
        end
        total = base + z;
      end
      total += longint'(DEG180);
      if (total < 0) total = 0;
      if (total > 360 * 65536) total = 360 * 65536;
      return 32'((total + 128) >>> 8);
    endfunction

    function void note_word(logic signed [AXW-1:0] ax, logic signed [AXW-1:0] ay,
                            logic signed [AXW-1:0] az, logic [TSW-1:0] t);
      longint mx, my, mz;
      int unsigned a1, a2, deg, sd;
      logic [TSW-1:0] age;
      face_result_t r;
      mx = scale_axis(ax); my = scale_axis(ay); mz = scale_axis(az);
      a1 = tilt_angle(-my, -mz);
      a2 = tilt_angle(-mx, -mz);
      if ((a1 > 70 * 256 && a1 < 100 * 256) || (a1 > 230 * 256 && a1 < 290 * 256))
        sd = n_sides;
      else begin
        deg = a2 >> 8;
        sd = (deg > 355) ? 0 : (deg * n_sides) / 360;
      end
      r.side = sd[SIDEW-1:0];
      r.report = 1'b0;
      r.stable = '0;
      if (r.side != prev_side) begin
        changed_at = t; prev_side = r.side; reported = 1'b0;
      end
      age = t - changed_at;
      if (age > {16'd0, hold} && !reported) begin
        reported = 1'b1; r.report = 1'b1; r.stable = r.side;
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(logic rv, logic [SIDEW-1:0] ss, logic [SIDEW-1:0] cs);
      face_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word rv=%0d ss=%0d cs=%0d", rv, ss, cs));
        return;
      end
      e = pending.pop_front();
      if (rv !== e.report || ss !== e.stable || cs !== e.side)
        report_mismatch($sformatf("got rv=%0d ss=%0d cs=%0d, want rv=%0d ss=%0d cs=%0d",
                                  rv, ss, cs, e.report, e.stable, e.side));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [AXW-1:0] accel_x_i, accel_y_i, accel_z_i;
  logic [TSW-1:0] now_ms_i;
  logic report_valid_o;
  logic [SIDEW-1:0] stable_side_o, current_side_o;

  face_scoreboard sb = new();
  logic no_idle = 1'b0;
  int cycles = 0;
  logic [TSW-1:0] clock_ms = 32'd0;
  int lo_cur = 265, hi_cur = 402, hold_cur = 5000;

  tilt_face_detect_debounce dut (.*);

  always #10 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the receiver in bursts and check each accepted word
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_word(report_valid_o, stable_side_o, current_side_o);
    if (!rst_ni || no_idle) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task apb_write(logic [1:0] idx, logic [DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Drop the sender, hold until every result is back, then let the block settle
  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task set_face_config(int ns, int lo, int hi, int hd);
    wait_drained();
    apb_write(REG_NSIDES, DW'(ns));
    apb_write(REG_MINRAW, DW'(lo));
    apb_write(REG_MAXRAW, DW'(hi));
    apb_write(REG_HOLD, DW'(hd));
    lo_cur = lo; hi_cur = hi; hold_cur = hd;
  endtask

  task send_word(int ax, int ay, int az, logic [TSW-1:0] t);
    int gap;
    gap = (!no_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i <= AXW'(ax); accel_y_i <= AXW'(ay); accel_z_i <= AXW'(az);
    now_ms_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(AXW'(ax), AXW'(ay), AXW'(az), t);
  endtask

  function int pick_axis();
    int a, b;
    if ($urandom_range(0, 7) == 0) return $signed(16'($urandom));
    a = (lo_cur < hi_cur) ? lo_cur : hi_cur;
    b = (lo_cur < hi_cur) ? hi_cur : lo_cur;
    a = (a - 20 < -32768) ? -32768 : a - 20;
    b = (b + 20 > 32767) ? 32767 : b + 20;
    return a + $urandom_range(0, b - a);
  endfunction

  // Random phase: runs of one orientation with time stepping around the hold
  task random_phase(int count);
    int sent, reps, ax, ay, az;
    sent = 0;
    while (sent < count) begin
      ax = pick_axis(); ay = pick_axis(); az = pick_axis();
      reps = $urandom_range(1, 8);
      for (int k = 0; k < reps && sent < count; k++) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 2 * hold_cur + 2);
        send_word(ax, ay, az, clock_ms);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0;
    accel_x_i <= '0; accel_y_i <= '0; accel_z_i <= '0; now_ms_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset setting, identity mapping for exact axis cases, then other bounds
    send_word(0, 0, 0, 32'd0);
    send_word(32767, -32768, 32767, 32'hFFFF_FFFF);
    send_word(-32768, 32767, -32768, 32'd6000);
    set_face_config(6, -90, 90, 0);
    send_word(0, 0, 0, 32'd10);
    send_word(0, 0, 5, 32'd11);
    send_word(0, 0, -5, 32'd12);
    send_word(5, 0, 0, 32'd13);
    send_word(-5, 0, 0, 32'd14);
    send_word(0, 5, 0, 32'd15);
    send_word(0, -5, 0, 32'd16);
    send_word(0, -5, 0, 32'd17);
    send_word(3, 4, -7, 32'd18);
    send_word(-7, 2, 9, 32'd30);
    set_face_config(64, -32768, 32767, 65535);
    send_word(32767, 0, -32768, 32'hFFFF_FFF0);
    send_word(32767, 0, -32768, 32'h0000_FFF0);
    send_word(32767, 0, -32768, 32'h0001_0000);
    set_face_config(1, 100, 100, 3);
    send_word(-32768, 32767, 0, 32'd0);
    send_word(5, 6, 7, 32'd4);
    set_face_config(13, 500, -500, 30);
    send_word(400, -300, 100, 32'd100);
    send_word(-500, 500, 0, 32'd200);

    // Random phases across several settings
    set_face_config(6, 265, 402, 5000);
    random_phase(150);
    set_face_config(64, -32768, 32767, 0);
    random_phase(150);
    set_face_config(1, -90, 90, 65535);
    random_phase(120);
    set_face_config(13, 500, -500, 30);
    random_phase(150);
    set_face_config(7, 1000, 1000, 10);
    random_phase(80);
    for (int p = 0; p < 3; p++) begin
      set_face_config($urandom_range(1, 64), $signed(16'($urandom)),
                      $signed(16'($urandom)), $urandom_range(0, 200));
      random_phase(100);
    end
    set_face_config(5, -200, 300, 50);
    no_idle = 1'b1;
    random_phase(150);

    // Drain and finish
    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/tfd_pkg.sv
rtl/core/tfd_div.sv
rtl/core/tfd_cordic.sv
rtl/core/tfd_datapath.sv
rtl/core/tfd_ctrl.sv
rtl/core/tilt_face_detect_debounce.sv
rtl/core/tfd_checker.sv
tb/tb_tilt_face_detect_debounce.sv
